[design/stl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package stl_pkg;

    typedef enum logic [5:0] {
        K_IDENT, K_NUM, K_RANGE, K_DOT, K_CADD, K_ADD, K_CSUB, K_ARROW, K_SUB,
        K_EXP, K_CMUL, K_MUL, K_CDIV, K_DIV, K_CMOD, K_MOD, K_CLSH, K_LE,
        K_LSH, K_LT, K_CRSH, K_GE, K_RSH, K_GT, K_AND, K_CBAND, K_BAND, K_OR,
        K_CBOR, K_BOR, K_CBXOR, K_BXOR, K_CBNOT, K_BNOT, K_NEQ, K_BANG, K_EQ,
        K_ASSIGN, K_LPAREN, K_RPAREN, K_LBRACK, K_RBRACK, K_LBRACE, K_RBRACE,
        K_SEMI, K_COLON, K_COMMA, K_HASH, K_DOLLAR, K_AT,
        K_STRING, K_COMMENT, K_WS, K_ERROR, K_END
    } kind_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;

    typedef struct packed {
        kind_t        kind;
        logic [15:0]  length;
        logic [19:0]  line;
        logic [15:0]  column;
        logic [31:0]  offset;
        logic         last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic logic is_dig(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alp(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic logic is_idc(input logic [7:0] c);
        return is_alp(c) || is_dig(c) || (c == "_");
    endfunction

    function automatic logic is_wsp(input logic [7:0] c);
        return c inside {" ", [8'd9:8'd13]};
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c inside {".", "+", "-", "*", "/", "%", "<", ">", "&", "|", "^", "!", "=",
                         "~"};
    endfunction

    function automatic kind_t op_single(input logic [7:0] c);
        kind_t k;
        case (c)
            ".":     k = K_DOT;
            "+":     k = K_ADD;
            "-":     k = K_SUB;
            "*":     k = K_MUL;
            "/":     k = K_DIV;
            "%":     k = K_MOD;
            "<":     k = K_LT;
            ">":     k = K_GT;
            "&":     k = K_BAND;
            "|":     k = K_BOR;
            "^":     k = K_BXOR;
            "!":     k = K_BANG;
            "=":     k = K_ASSIGN;
            default: k = K_BNOT;
        endcase
        return k;
    endfunction

    // {hit, kind} for a two-character operator
    function automatic logic [6:0] op_pair(input logic [7:0] f, input logic [7:0] c);
        logic  hit;
        kind_t k;
        hit = 1'b1;
        k   = K_DOT;
        case (f)
            ".":     if (c == ".") k = K_RANGE; else hit = 1'b0;
            "+":     if (c == "=") k = K_CADD; else hit = 1'b0;
            "-":     if (c == "=") k = K_CSUB; else if (c == ">") k = K_ARROW;
                     else hit = 1'b0;
            "*":     if (c == "*") k = K_EXP; else if (c == "=") k = K_CMUL;
                     else hit = 1'b0;
            "/":     if (c == "=") k = K_CDIV; else hit = 1'b0;
            "%":     if (c == "=") k = K_CMOD; else hit = 1'b0;
            "<":     if (c == "=") k = K_LE; else hit = 1'b0;
            ">":     if (c == "=") k = K_GE; else hit = 1'b0;
            "&":     if (c == "&") k = K_AND; else if (c == "=") k = K_CBAND;
                     else hit = 1'b0;
            "|":     if (c == "|") k = K_OR; else if (c == "=") k = K_CBOR;
                     else hit = 1'b0;
            "^":     if (c == "=") k = K_CBXOR; else hit = 1'b0;
            "~":     if (c == "=") k = K_CBNOT; else hit = 1'b0;
            "!":     if (c == "=") k = K_NEQ; else hit = 1'b0;
            "=":     if (c == "=") k = K_EQ; else hit = 1'b0;
            default: hit = 1'b0;
        endcase
        return {hit, k};
    endfunction

    function automatic logic [6:0] punct(input logic [7:0] c);
        logic  hit;
        kind_t k;
        hit = 1'b1;
        case (c)
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "[":     k = K_LBRACK;
            "]":     k = K_RBRACK;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            ";":     k = K_SEMI;
            ":":     k = K_COLON;
            ",":     k = K_COMMA;
            "#":     k = K_HASH;
            "$":     k = K_DOLLAR;
            "@":     k = K_AT;
            default:
            begin
                hit = 1'b0;
                k   = K_LPAREN;
            end
        endcase
        return {hit, k};
    endfunction

endpackage
`default_nettype wire

[design/stl_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface stl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

interface stl_token_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [15:0] token_length;
    logic [19:0] token_line;
    logic [15:0] token_column;
    logic [31:0] token_offset;
    logic        last_result;
    modport source (output valid, output token_kind, output token_length, output token_line,
                    output token_column, output token_offset, output last_result,
                    input ready);
    modport sink (input valid, input token_kind, input token_length, input token_line,
                  input token_column, input token_offset, input last_result,
                  output ready);
endinterface
`default_nettype wire

[design/stl_core.sv]
`timescale 1ns / 1ps
`default_nettype none
module stl_core
    import stl_pkg::*;
#(
    parameter int LB = 16,
    parameter int NB = 20
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] char_in,
    output push_t           push
);

    typedef enum logic [11:0] {
        M_IDLE    = 12'b000000000001,
        M_IDENT   = 12'b000000000010,
        M_INT     = 12'b000000000100,
        M_INTDOT  = 12'b000000001000,
        M_FRAC    = 12'b000000010000,
        M_WS      = 12'b000000100000,
        M_COMMENT = 12'b000001000000,
        M_STR     = 12'b000010000000,
        M_STRWS   = 12'b000100000000,
        M_ERR     = 12'b001000000000,
        M_SHIFT   = 12'b010000000000,
        M_OP      = 12'b100000000000
    } mode_t;

    localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};
    localparam logic [NB-1:0] LN_MAX  = {NB{1'b1}};
    localparam logic [LB-1:0] LEN_ONE = LB'(1);

    mode_t          mode_reg, mode_next;
    logic [7:0]     first_reg, first_next;
    logic [LB-1:0]  len_reg, len_next, serr_reg, serr_next;
    logic [NB-1:0]  sline_reg, sline_next, cline_reg, cline_next;
    logic [LB-1:0]  scol_reg, scol_next, ccol_reg, ccol_next;
    logic [31:0]    soff_reg, soff_next, coff_reg, coff_next;

    function automatic logic [LB-1:0] inc_len(input logic [LB-1:0] x);
        return (x == LEN_MAX) ? x : x + LEN_ONE;
    endfunction

    function automatic result_t mk(input kind_t k, input logic [LB-1:0] len,
                                   input logic [NB-1:0] ln, input logic [LB-1:0] col,
                                   input logic [31:0] off);
        result_t r;
        r.kind   = k;
        r.length = 16'(32'(len));
        r.line   = 20'(32'(ln));
        r.column = 16'(32'(col));
        r.offset = off;
        r.last   = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        logic       restart;
        logic       e0_v, e1_v;
        result_t    e0, e1, ef;
        logic [6:0] pr, pu;
        logic       f_emit;

        restart    = 1'b0;
        e0_v       = 1'b0;
        e1_v       = 1'b0;
        e0         = mk(K_END, '0, sline_reg, scol_reg, soff_reg);
        e1         = e0;
        ef         = e0;
        f_emit     = 1'b0;
        mode_next  = mode_reg;
        first_next = first_reg;
        len_next   = len_reg;
        serr_next  = serr_reg;
        sline_next = sline_reg;
        scol_next  = scol_reg;
        soff_next  = soff_reg;
        pr         = op_pair(first_reg, char_in);
        pu         = punct(char_in);

        case (mode_reg)
            M_IDLE: restart = 1'b1;
            M_IDENT, M_INT, M_FRAC, M_WS:
            begin
                if ((mode_reg == M_IDENT) ? is_idc(char_in) :
                    (mode_reg == M_WS) ? is_wsp(char_in) : is_dig(char_in))
                begin
                    len_next = inc_len(len_reg);
                end
                else if (mode_reg == M_INT && char_in == CH_DOT)
                begin
                    mode_next = M_INTDOT;
                end
                else
                begin
                    e0_v    = 1'b1;
                    e0      = mk((mode_reg == M_IDENT) ? K_IDENT :
                                 (mode_reg == M_WS) ? K_WS : K_NUM,
                                 len_reg, sline_reg, scol_reg, soff_reg);
                    restart = 1'b1;
                end
            end
            M_INTDOT:
            begin
                if (char_in == CH_DOT)
                begin
                    e0_v      = 1'b1;
                    e0        = mk(K_NUM, len_reg, sline_reg, scol_reg, soff_reg);
                    e1_v      = 1'b1;
                    e1        = mk(K_RANGE, LB'(2), cline_reg, ccol_reg - LEN_ONE,
                                   coff_reg - 32'd1);
                    mode_next = M_IDLE;
                end
                else if (is_dig(char_in))
                begin
                    len_next  = inc_len(inc_len(len_reg));
                    mode_next = M_FRAC;
                end
                else
                begin
                    e0_v    = 1'b1;
                    e0      = mk(K_NUM, inc_len(len_reg), sline_reg, scol_reg, soff_reg);
                    restart = 1'b1;
                end
            end
            M_COMMENT, M_ERR:
            begin
                if ((mode_reg == M_COMMENT) ? (char_in == CH_NL || char_in == CH_NUL) :
                    (is_wsp(char_in) || char_in == CH_NUL))
                begin
                    e0_v    = 1'b1;
                    e0      = mk((mode_reg == M_COMMENT) ? K_COMMENT : K_ERROR,
                                 len_reg, sline_reg, scol_reg, soff_reg);
                    restart = 1'b1;
                end
                else
                begin
                    len_next = inc_len(len_reg);
                end
            end
            M_STR, M_STRWS:
            begin
                if (char_in == CH_QUOTE)
                begin
                    e0_v      = 1'b1;
                    e0        = mk(K_STRING, len_reg, sline_reg, scol_reg, soff_reg);
                    mode_next = M_IDLE;
                end
                else if (char_in == CH_NUL)
                begin
                    e0_v    = 1'b1;
                    e0      = mk(K_ERROR, serr_reg, sline_reg, inc_len(scol_reg),
                                 (soff_reg == 32'hFFFF_FFFF) ? soff_reg : soff_reg + 32'd1);
                    restart = 1'b1;
                end
                else
                begin
                    len_next = inc_len(len_reg);
                    if (mode_reg == M_STR)
                    begin
                        if (is_wsp(char_in))
                            mode_next = M_STRWS;
                        else
                            serr_next = inc_len(serr_reg);
                    end
                end
            end
            M_SHIFT:
            begin
                e0_v = 1'b1;
                if (char_in == CH_EQ)
                begin
                    e0        = mk((first_reg == CH_LT) ? K_CLSH : K_CRSH, LB'(3),
                                   sline_reg, scol_reg, soff_reg);
                    mode_next = M_IDLE;
                end
                else
                begin
                    e0      = mk((first_reg == CH_LT) ? K_LSH : K_RSH, LB'(2),
                                 sline_reg, scol_reg, soff_reg);
                    restart = 1'b1;
                end
            end
            M_OP:
            begin
                if ((first_reg == CH_LT || first_reg == CH_GT) && char_in == first_reg)
                begin
                    mode_next = M_SHIFT;
                    len_next  = LB'(2);
                end
                else if (pr[6])
                begin
                    e0_v      = 1'b1;
                    e0        = mk(kind_t'(pr[5:0]), LB'(2), sline_reg, scol_reg, soff_reg);
                    mode_next = M_IDLE;
                end
                else
                begin
                    e0_v    = 1'b1;
                    e0      = mk(op_single(first_reg), LEN_ONE, sline_reg, scol_reg,
                                 soff_reg);
                    restart = 1'b1;
                end
            end
            default: restart = 1'b1;
        endcase

        if (restart)
        begin
            sline_next = cline_reg;
            scol_next  = ccol_reg;
            soff_next  = coff_reg;
            len_next   = LEN_ONE;
            f_emit     = 1'b0;
            ef         = mk(kind_t'(pu[5:0]), LEN_ONE, cline_reg, ccol_reg, coff_reg);
            mode_next  = M_IDLE;
            if (is_alp(char_in))
                mode_next = M_IDENT;
            else if (is_dig(char_in))
                mode_next = M_INT;
            else if (is_op(char_in))
            begin
                mode_next  = M_OP;
                first_next = char_in;
            end
            else if (is_wsp(char_in))
                mode_next = M_WS;
            else if (pu[6])
                f_emit = 1'b1;
            else if (char_in == CH_QUOTE)
            begin
                mode_next = M_STR;
                len_next  = '0;
                serr_next = '0;
            end
            else if (char_in == CH_QMARK)
                mode_next = M_COMMENT;
            else if (char_in == CH_NUL)
            begin
                f_emit = 1'b1;
                ef     = mk(K_END, '0, cline_reg, ccol_reg, coff_reg);
            end
            else
                mode_next = M_ERR;
            if (f_emit)
            begin
                if (e0_v)
                begin
                    e1_v = 1'b1;
                    e1   = ef;
                end
                else
                begin
                    e0_v = 1'b1;
                    e0   = ef;
                end
            end
        end

        if (e1_v)
            e1.last = 1'b1;
        else
            e0.last = 1'b1;

        push.r0    = e0;
        push.r1    = e1;
        push.count = accept ? ({1'b0, e0_v} + {1'b0, e1_v}) : 2'd0;

        coff_next = (coff_reg == 32'hFFFF_FFFF) ? coff_reg : coff_reg + 32'd1;
        if (char_in == CH_NL)
        begin
            cline_next = (cline_reg == LN_MAX) ? cline_reg : cline_reg + NB'(1);
            ccol_next  = LEN_ONE;
        end
        else
        begin
            cline_next = cline_reg;
            ccol_next  = inc_len(ccol_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            first_reg <= '0;
            len_reg   <= '0;
            serr_reg  <= '0;
            sline_reg <= NB'(1);
            scol_reg  <= LEN_ONE;
            soff_reg  <= '0;
            cline_reg <= NB'(1);
            ccol_reg  <= LEN_ONE;
            coff_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            first_reg <= first_next;
            len_reg   <= len_next;
            serr_reg  <= serr_next;
            sline_reg <= sline_next;
            scol_reg  <= scol_next;
            soff_reg  <= soff_next;
            cline_reg <= cline_next;
            ccol_reg  <= ccol_next;
            coff_reg  <= coff_next;
        end
    end

endmodule
`default_nettype wire

[design/stl_outq.sv]
`timescale 1ns / 1ps
`default_nettype none
module stl_outq
    import stl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  push_t       push,
    output logic        room,
    stl_token_if.source tok
);

    result_t    mem [4];
    logic [1:0] head_reg, head_next, tail_reg, tail_next;
    logic [2:0] count_reg, count_next;
    logic       pop;
    result_t    hd;

    assign hd               = mem[head_reg];
    assign tok.valid        = (count_reg != 3'd0);
    assign tok.token_kind   = hd.kind;
    assign tok.token_length = hd.length;
    assign tok.token_line   = hd.line;
    assign tok.token_column = hd.column;
    assign tok.token_offset = hd.offset;
    assign tok.last_result  = hd.last;
    assign pop              = tok.valid && tok.ready;
    assign room             = (count_reg <= 3'd2);
    assign head_next        = head_reg + {1'b0, pop};
    assign tail_next        = tail_reg + push.count;
    assign count_next       = count_reg + {1'b0, push.count} - {2'b0, pop};

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[tail_reg] <= push.r0;
        if (push.count == 2'd2)
            mem[tail_reg + 2'd1] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

[design/source_token_lexer.sv]
`timescale 1ns / 1ps
`default_nettype none
// Streaming source lexer: one text byte per request on char_ch, finished tokens on
// token_ch, up to two per byte, last_result marking the final one for a byte. Each
// byte is classified combinationally against the pending-token state; results go into a
// four-entry output queue, so a byte is taken every cycle while the queue holds two
// or fewer results. Sustained rate is one byte per cycle when bytes give at most one
// token each and the sink is always ready; a byte giving two tokens fills the queue faster.
module source_token_lexer
    import stl_pkg::*;
#(
    parameter int LENGTH_BITS = 16,
    parameter int LINE_BITS   = 20
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    stl_char_if.sink    char_ch,
    stl_token_if.source token_ch
);

    push_t push;
    logic  room;
    logic  accept;

    assign char_ch.ready = room;
    assign accept        = char_ch.valid && room;

    stl_core #(
        .LB (LENGTH_BITS),
        .NB (LINE_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .char_in (char_ch.char_in),
        .push    (push)
    );

    stl_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .tok   (token_ch)
    );

endmodule
`default_nettype wire

[design/stl_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module stl_checker
    import stl_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [5:0]  out_kind,
    input wire logic [15:0] out_length,
    input wire logic        out_last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_last))
        else $error("stalled token changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_kind <= K_END)
        else $error("token kind out of range");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == K_END |-> out_last && out_length == 16'd0)
        else $error("end token not last or nonzero length");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == K_RANGE |-> out_last && out_length == 16'd2)
        else $error("range token malformed");

endmodule

bind source_token_lexer stl_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (token_ch.valid),
    .out_ready  (token_ch.ready),
    .out_kind   (token_ch.token_kind),
    .out_length (token_ch.token_length),
    .out_last   (token_ch.last_result)
);
`default_nettype wire

[tb/source_token_lexer_tb.sv]
`timescale 1ns / 1ps
module source_token_lexer_tb;
    import stl_pkg::*;

    localparam logic [15:0] LEN_SAT  = 16'hFFFF;
    localparam logic [19:0] LINE_SAT = 20'hFFFFF;
    localparam logic [31:0] OFF_SAT  = 32'hFFFF_FFFF;

    typedef enum logic [4:0] {
        LX_IDLE, LX_IDENT, LX_INT, LX_INTDOT, LX_FRAC, LX_WS, LX_COMMENT, LX_STR,
        LX_STRWS, LX_ERR, LX_LSHIFT, LX_RSHIFT, LX_OP
    } lex_mode_t;

    typedef struct {
        kind_t       kind;
        logic [15:0] length;
        logic [19:0] line;
        logic [15:0] column;
        logic [31:0] offset;
        logic        last;
    } token_t;

    logic clk;
    logic rst_n;

    stl_char_if  char_ch ();
    stl_token_if token_ch ();

    source_token_lexer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_ch  (char_ch.sink),
        .token_ch (token_ch.source)
    );

    lex_mode_t   lx_mode;
    logic [7:0]  lx_opchar;
    logic [15:0] lx_len;
    logic [15:0] lx_strerr;
    logic [19:0] tok_line;
    logic [15:0] tok_col;
    logic [31:0] tok_off;
    logic [19:0] cur_line;
    logic [15:0] cur_col;
    logic [31:0] cur_off;

    token_t expected_tokens[$];
    token_t step_tokens[$];
    int     error_count;
    int     mismatch_count;
    bit     hold_sink;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [15:0] len_inc(input logic [15:0] v);
        return (v == LEN_SAT) ? v : v + 16'd1;
    endfunction

    function automatic logic dec_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_opchar(input logic [7:0] c);
        case (c)
            ".", "+", "-", "*", "/", "%", "<", ">", "&", "|", "^", "!", "=", "~":
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic kind_t single_op_kind(input logic [7:0] c);
        case (c)
            ".":     return K_DOT;
            "+":     return K_ADD;
            "-":     return K_SUB;
            "*":     return K_MUL;
            "/":     return K_DIV;
            "%":     return K_MOD;
            "<":     return K_LT;
            ">":     return K_GT;
            "&":     return K_BAND;
            "|":     return K_BOR;
            "^":     return K_BXOR;
            "!":     return K_BANG;
            "=":     return K_ASSIGN;
            default: return K_BNOT;
        endcase
    endfunction

    function automatic bit pair_op_kind(input logic [7:0] f, input logic [7:0] c,
                                        output kind_t k);
        k = K_DOT;
        case ({f, c})
            {".", "."}: k = K_RANGE;
            {"+", "="}: k = K_CADD;
            {"-", "="}: k = K_CSUB;
            {"-", ">"}: k = K_ARROW;
            {"*", "*"}: k = K_EXP;
            {"*", "="}: k = K_CMUL;
            {"/", "="}: k = K_CDIV;
            {"%", "="}: k = K_CMOD;
            {"<", "="}: k = K_LE;
            {">", "="}: k = K_GE;
            {"&", "&"}: k = K_AND;
            {"&", "="}: k = K_CBAND;
            {"|", "|"}: k = K_OR;
            {"|", "="}: k = K_CBOR;
            {"^", "="}: k = K_CBXOR;
            {"~", "="}: k = K_CBNOT;
            {"!", "="}: k = K_NEQ;
            {"=", "="}: k = K_EQ;
            default:    return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic bit punct_kind(input logic [7:0] c, output kind_t k);
        k = K_LPAREN;
        case (c)
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "[":     k = K_LBRACK;
            "]":     k = K_RBRACK;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            ";":     k = K_SEMI;
            ":":     k = K_COLON;
            ",":     k = K_COMMA;
            "#":     k = K_HASH;
            "$":     k = K_DOLLAR;
            "@":     k = K_AT;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    task automatic push_token(input kind_t k, input logic [15:0] len, input logic [19:0] ln,
                              input logic [15:0] col, input logic [31:0] off);
        token_t t;
        t.kind   = k;
        t.length = len;
        t.line   = ln;
        t.column = col;
        t.offset = off;
        t.last   = 1'b0;
        step_tokens.push_back(t);
    endtask

    task automatic finish_pending(input kind_t k, input logic [15:0] len);
        lx_mode = LX_IDLE;
        push_token(k, len, tok_line, tok_col, tok_off);
    endtask

    task automatic start_token(input logic [7:0] c);
        kind_t k;
        tok_line = cur_line;
        tok_col  = cur_col;
        tok_off  = cur_off;
        lx_len   = 16'd1;
        lx_mode  = LX_IDLE;
        if (is_letter(c))
            lx_mode = LX_IDENT;
        else if (dec_digit(c))
            lx_mode = LX_INT;
        else if (is_opchar(c))
        begin
            lx_mode   = LX_OP;
            lx_opchar = c;
        end
        else if (is_space(c))
            lx_mode = LX_WS;
        else if (punct_kind(c, k))
            finish_pending(k, 16'd1);
        else if (c == CH_QUOTE)
        begin
            lx_mode   = LX_STR;
            lx_len    = 16'd0;
            lx_strerr = 16'd0;
        end
        else if (c == CH_QMARK)
            lx_mode = LX_COMMENT;
        else if (c == CH_NUL)
            finish_pending(K_END, 16'd0);
        else
            lx_mode = LX_ERR;
    endtask

    task automatic predict_tokens(input logic [7:0] c);
        bit    restart;
        bit    more;
        kind_t k;
        restart = 1'b0;
        step_tokens.delete();
        case (lx_mode)
            LX_IDLE:
                restart = 1'b1;
            LX_IDENT, LX_INT, LX_FRAC, LX_WS:
            begin
                if (lx_mode == LX_IDENT)
                    more = is_letter(c) || dec_digit(c) || c == "_";
                else if (lx_mode == LX_WS)
                    more = is_space(c);
                else
                    more = dec_digit(c);
                if (more)
                    lx_len = len_inc(lx_len);
                else if (lx_mode == LX_INT && c == CH_DOT)
                    lx_mode = LX_INTDOT;
                else
                begin
                    finish_pending(lx_mode == LX_IDENT ? K_IDENT :
                                   lx_mode == LX_WS ? K_WS : K_NUM, lx_len);
                    restart = 1'b1;
                end
            end
            LX_INTDOT:
                if (c == CH_DOT)
                begin
                    finish_pending(K_NUM, lx_len);
                    push_token(K_RANGE, 16'd2, cur_line, cur_col - 16'd1, cur_off - 32'd1);
                end
                else if (dec_digit(c))
                begin
                    lx_len  = len_inc(len_inc(lx_len));
                    lx_mode = LX_FRAC;
                end
                else
                begin
                    finish_pending(K_NUM, len_inc(lx_len));
                    restart = 1'b1;
                end
            LX_COMMENT, LX_ERR:
                if (lx_mode == LX_COMMENT ? (c == CH_NL || c == CH_NUL)
                                          : (is_space(c) || c == CH_NUL))
                begin
                    finish_pending(lx_mode == LX_COMMENT ? K_COMMENT : K_ERROR, lx_len);
                    restart = 1'b1;
                end
                else
                    lx_len = len_inc(lx_len);
            LX_STR, LX_STRWS:
                if (c == CH_QUOTE)
                    finish_pending(K_STRING, lx_len);
                else if (c == CH_NUL)
                begin
                    lx_mode = LX_IDLE;
                    push_token(K_ERROR, lx_strerr, tok_line, len_inc(tok_col),
                               tok_off == OFF_SAT ? tok_off : tok_off + 32'd1);
                    restart = 1'b1;
                end
                else
                begin
                    lx_len = len_inc(lx_len);
                    if (lx_mode == LX_STR)
                    begin
                        if (is_space(c))
                            lx_mode = LX_STRWS;
                        else
                            lx_strerr = len_inc(lx_strerr);
                    end
                end
            LX_LSHIFT, LX_RSHIFT:
                if (c == CH_EQ)
                    finish_pending(lx_mode == LX_LSHIFT ? K_CLSH : K_CRSH, 16'd3);
                else
                begin
                    finish_pending(lx_mode == LX_LSHIFT ? K_LSH : K_RSH, 16'd2);
                    restart = 1'b1;
                end
            LX_OP:
                if ((lx_opchar == CH_LT || lx_opchar == CH_GT) && c == lx_opchar)
                begin
                    lx_mode = (lx_opchar == CH_LT) ? LX_LSHIFT : LX_RSHIFT;
                    lx_len  = 16'd2;
                end
                else if (pair_op_kind(lx_opchar, c, k))
                    finish_pending(k, 16'd2);
                else
                begin
                    finish_pending(single_op_kind(lx_opchar), 16'd1);
                    restart = 1'b1;
                end
            default:
                restart = 1'b1;
        endcase
        if (restart)
            start_token(c);
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);
        if (cur_off != OFF_SAT)
            cur_off = cur_off + 32'd1;
        if (c == CH_NL)
        begin
            if (cur_line != LINE_SAT)
                cur_line = cur_line + 20'd1;
            cur_col = 16'd1;
        end
        else
            cur_col = len_inc(cur_col);
    endtask

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_ch.valid   <= 1'b1;
        char_ch.char_in <= c;
        do
            @(posedge clk);
        while (!char_ch.ready);
        predict_tokens(c);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic wait_drained;
        char_ch.valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        token_t e;
        if (rst_n && token_ch.valid && token_ch.ready)
        begin
            if (expected_tokens.size() == 0)
            begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected token kind=%0d off=%0d",
                             token_ch.token_kind, token_ch.token_offset);
            end
            else
            begin
                e = expected_tokens.pop_front();
                if (token_ch.token_kind !== e.kind || token_ch.token_length !== e.length ||
                    token_ch.token_line !== e.line || token_ch.token_column !== e.column ||
                    token_ch.token_offset !== e.offset || token_ch.last_result !== e.last)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch exp k=%0d len=%0d ln=%0d col=%0d off=%0d last=%0d %s",
                                 e.kind, e.length, e.line, e.column, e.offset, e.last,
                                 $sformatf("got k=%0d len=%0d ln=%0d col=%0d off=%0d last=%0d",
                                           token_ch.token_kind, token_ch.token_length,
                                           token_ch.token_line, token_ch.token_column,
                                           token_ch.token_offset, token_ch.last_result));
                end
            end
        end
    end

    // sink stalls
    initial
    begin
        int gap;
        token_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
                token_ch.ready <= 1'b0;
            else
            begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
                if (gap != 0)
                begin
                    token_ch.ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                token_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] random_char;
        string ops;
        string puncs;
        ops   = ".+-*/%<>&|^!=~";
        puncs = "()[]{};:,#$@";
        case ($urandom_range(0, 11))
            0, 1:    return 8'("a" + $urandom_range(0, 25));
            2:       return 8'("0" + $urandom_range(0, 9));
            3:       return " ";
            4:       return CH_NL;
            5, 6:    return ops[$urandom_range(0, 13)];
            7:       return puncs[$urandom_range(0, 11)];
            8:       return CH_QUOTE;
            9:       return CH_QMARK;
            10:      return ($urandom_range(0, 3) == 0) ? CH_NUL : "_";
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_tokens;
        send_text("ab_9 12 3.5 7.x 4..");
        send_char(CH_NUL);
        send_text("<<= >>= << >> -> ** && || != == ~= ^= %= /= *= += -= &= |= <= >=");
        send_char(CH_NL);
        send_text(". + - * / % < > & | ^ ! = ~ ( ) [ ] { } ; : , # $ @ ");
        send_text("\"s t\"\"ab c");
        send_char(CH_NUL);
        send_text("?note");
        send_char(CH_NUL);
        send_text("?x\n'q\t");
        send_char(8'hFF);
        send_char(8'h80);
        send_char(8'h01);
        send_char(CH_NUL);
        wait_drained();
    endtask

    task automatic test_random;
        string frags[10];
        frags = '{"foo", "x1_y", "123", "4.56", "9..", "<<=", "a+=b", "\"hi there\"",
                  "?c\n", " \t"};
        for (int i = 0; i < 70; i++)
        begin
            if ($urandom_range(0, 2) == 0)
                send_char(random_char());
            else
                send_text(frags[$urandom_range(0, 9)]);
        end
        send_char(CH_NUL);
        wait_drained();
    endtask

    task automatic test_backpressure;
        fork
            begin
                hold_sink = 1'b1;
                repeat (60) @(posedge clk);
                hold_sink = 1'b0;
            end
            for (int i = 0; i < 30; i++)
                send_char(random_char());
        join
        send_char(CH_NUL);
        wait_drained();
    endtask

    task automatic test_long_tokens;
        send_char("?");
        for (int i = 0; i < 40; i++)
            send_char("z");
        send_char(CH_NL);
        send_char(CH_NUL);
        wait_drained();
    endtask

    initial
    begin
        timeout_guard();
    end

    task automatic timeout_guard;
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        char_ch.valid   = 1'b0;
        char_ch.char_in = 8'd0;
        hold_sink       = 1'b0;
        error_count     = 0;
        mismatch_count  = 0;
        lx_mode   = LX_IDLE;
        lx_opchar = 8'd0;
        lx_len    = 16'd0;
        lx_strerr = 16'd0;
        tok_line  = 20'd1;
        tok_col   = 16'd1;
        tok_off   = 32'd0;
        cur_line  = 20'd1;
        cur_col   = 16'd1;
        cur_off   = 32'd0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_tokens();
        test_random();
        test_backpressure();
        test_long_tokens();
        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_tokens.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
